### rtl/fpv_pkg.sv
// shared types for the first point per voxel filter
// command and status bundles between controller and datapath, state encoding
package fpv_pkg;

  localparam int unsigned CoordWidth = 32;
  localparam int unsigned InvWidth   = 32;
  localparam int unsigned VoxWidth   = 48;
  localparam logic [InvWidth-1:0] InvCellReset = 32'd65536000;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_MUL   = 7'b0000100,
    S_VOX   = 7'b0001000,
    S_OFF   = 7'b0010000,
    S_RD    = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  typedef struct packed {
    logic clear_step;
    logic capture;
    logic mul;
    logic vox;
    logic off;
    logic rd;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
  } status_t;

endpackage

### rtl/fpv_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
module fpv_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/fpv_ctrl.sv
// sequencing state machine: clear pass, per point steps, output beat register
// uses fpv_pkg
module fpv_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  fpv_pkg::status_t status,
  output fpv_pkg::cmd_t    cmd
);

  import fpv_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   slot_free;

  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_VOX;
      end
      S_VOX: begin
        cmd.vox    = 1'b1;
        state_next = S_OFF;
      end
      S_OFF: begin
        cmd.off    = 1'b1;
        state_next = S_RD;
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        // hold the looked-up row until the output slot is free
        if (slot_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.commit) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

### rtl/fpv_datapath.sv
// voxel index arithmetic, pivot, window check and occupancy bitmap access
// uses fpv_pkg and fpv_ram
module fpv_datapath #(
  parameter int unsigned GRID_BITS = 6
) (
  input  logic                           clk,
  input  logic                           rst,
  input  fpv_pkg::cmd_t                  cmd,
  output fpv_pkg::status_t               status,
  input  logic                           cfg_valid,
  input  logic [fpv_pkg::InvWidth-1:0]   inv_cell_q16,
  input  logic signed [fpv_pkg::CoordWidth-1:0] coord_x,
  input  logic signed [fpv_pkg::CoordWidth-1:0] coord_y,
  input  logic signed [fpv_pkg::CoordWidth-1:0] coord_z,
  output logic                           keep_point,
  output logic                           outside_window
);

  import fpv_pkg::*;

  localparam int unsigned Side     = 1 << GRID_BITS;
  localparam int unsigned RowBits  = 2 * GRID_BITS;
  localparam int unsigned Rows     = 1 << RowBits;
  localparam int unsigned QWidth   = VoxWidth - 1;
  localparam int unsigned DiffW    = VoxWidth + 1;
  localparam int unsigned ProdW    = CoordWidth + InvWidth;

  logic [InvWidth-1:0]            inv_cell;
  logic [2:0][CoordWidth-1:0]     coord;
  logic [2:0][CoordWidth-1:0]     mag;
  logic [2:0]                     neg;
  logic [2:0][QWidth-1:0]         q;
  logic [2:0][VoxWidth-1:0]       vox;
  logic [2:0][VoxWidth-1:0]       pivot;
  logic                           pivot_valid;
  logic [2:0][GRID_BITS-1:0]      off_idx;
  logic [2:0]                     axis_in;
  logic [2:0][GRID_BITS-1:0]      off_idx_next;
  logic [2:0][ProdW-1:0]          prod;
  logic [2:0][DiffW-1:0]          diff;
  logic                           in_win;
  logic [RowBits-1:0]             clr_cnt;
  logic [RowBits-1:0]             row;
  logic                           ram_wr_en;
  logic [RowBits-1:0]             ram_wr_addr;
  logic [Side-1:0]                ram_wr_data;
  logic [Side-1:0]                ram_rd_data;
  logic                           bit_set;

  assign coord[0] = coord_x;
  assign coord[1] = coord_y;
  assign coord[2] = coord_z;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      logic [VoxWidth-1:0] piv_sel;
      logic [DiffW-1:0]    hi_bits;
      piv_sel = pivot_valid ? pivot[a] : vox[a];
      prod[a] = ProdW'(mag[a]) * ProdW'(inv_cell);
      diff[a] = {vox[a][VoxWidth-1], vox[a]} - {piv_sel[VoxWidth-1], piv_sel};
      // in window when every bit from the half-window sign bit up agrees
      hi_bits = diff[a] >> (GRID_BITS - 1);
      axis_in[a] = (hi_bits == '0) || (hi_bits == (DiffW'({DiffW{1'b1}}) >> (GRID_BITS - 1)));
      off_idx_next[a] = {~diff[a][GRID_BITS-1], diff[a][GRID_BITS-2:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_cell <= InvCellReset;
    end else if (cfg_valid) begin
      inv_cell <= inv_cell_q16;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pivot_valid <= 1'b0;
      pivot       <= '0;
      clr_cnt     <= '0;
    end else begin
      if (cmd.off && !pivot_valid) begin
        pivot       <= vox;
        pivot_valid <= 1'b1;
      end
      if (cmd.clear_step) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      if (cmd.capture) begin
        neg[a] <= coord[a][CoordWidth-1];
        mag[a] <= coord[a][CoordWidth-1] ? (~coord[a] + 1'b1) : coord[a];
      end
      if (cmd.mul) begin
        q[a] <= prod[a][16 +: QWidth];
      end
      if (cmd.vox) begin
        vox[a] <= neg[a] ? (VoxWidth'(0) - {1'b0, q[a]}) : {1'b0, q[a]};
      end
      if (cmd.off) begin
        off_idx[a] <= off_idx_next[a];
      end
    end
    if (cmd.off) begin
      in_win <= &axis_in;
    end
    if (cmd.commit) begin
      keep_point     <= in_win && !bit_set;
      outside_window <= !in_win;
    end
  end

  assign status.clear_last = &clr_cnt;

  // row holds the x bits of one (z, y) pair
  assign row     = {off_idx[2], off_idx[1]};
  assign bit_set = ram_rd_data[off_idx[0]];

  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = row;
    ram_wr_data = ram_rd_data | (Side'(1) << off_idx[0]);
    if (cmd.clear_step) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = clr_cnt;
      ram_wr_data = '0;
    end else if (cmd.commit && in_win && !bit_set) begin
      ram_wr_en = 1'b1;
    end
  end

  fpv_ram #(
    .WIDTH (Side),
    .DEPTH (Rows)
  ) u_occ_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (cmd.rd),
    .rd_addr (row),
    .rd_data (ram_rd_data)
  );

endmodule

### rtl/first_point_per_voxel_filter_core.sv
// top level of the first point per voxel filter
// joins fpv_ctrl and fpv_datapath, uses fpv_pkg
//
// After reset the block clears its occupancy bitmap, one row of 2^GRID_BITS
// bits per cycle, all 2^(2*GRID_BITS) rows (4096 at the default), with
// in_stall high. Then each point runs the fixed step sequence, and no new
// point is taken until the last one is through: capture and magnitude,
// Q16.16 multiply, sign restore, pivot offset and window check, bitmap
// row read, bitmap row write. A finished result waits in the output
// register while the next point is taken; a stalled output holds the
// datapath only at the last step. cfg_ready is always high; write
// inv_cell_q16 only while no point is in flight.
module first_point_per_voxel_filter_core #(
  parameter int unsigned GRID_BITS = 6
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [fpv_pkg::InvWidth-1:0]          inv_cell_q16,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [fpv_pkg::CoordWidth-1:0] coord_x,
  input  logic signed [fpv_pkg::CoordWidth-1:0] coord_y,
  input  logic signed [fpv_pkg::CoordWidth-1:0] coord_z,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  keep_point,
  output logic                                  outside_window
);

  import fpv_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  fpv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  fpv_datapath #(
    .GRID_BITS (GRID_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_valid      (cfg_valid),
    .inv_cell_q16   (inv_cell_q16),
    .coord_x        (coord_x),
    .coord_y        (coord_y),
    .coord_z        (coord_z),
    .keep_point     (keep_point),
    .outside_window (outside_window)
  );

endmodule

### dv/fpv_checker.sv
// verdict checker for the first point per voxel filter core
// watches the config, point and verdict channels, predicts keep/outside per point
// depends on fpv_pkg for the coordinate and reciprocal widths
module fpv_checker #(
  parameter int unsigned GRID_BITS = 6
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  input  logic                                  cfg_ready,
  input  logic [fpv_pkg::InvWidth-1:0]          inv_cell_q16,
  input  logic                                  in_valid,
  input  logic                                  in_stall,
  input  logic signed [fpv_pkg::CoordWidth-1:0] coord_x,
  input  logic signed [fpv_pkg::CoordWidth-1:0] coord_y,
  input  logic signed [fpv_pkg::CoordWidth-1:0] coord_z,
  input  logic                                  out_valid,
  input  logic                                  out_stall,
  input  logic                                  keep_point,
  input  logic                                  outside_window,
  output int                                    fail_count,
  output int                                    pending
);

  localparam longint Side = longint'(1) << GRID_BITS;
  localparam longint Half = Side / 2;
  localparam int unsigned Cells = 1 << (3 * GRID_BITS);

  typedef struct packed {
    logic keep;
    logic outside;
  } verdict_t;

  logic [fpv_pkg::InvWidth-1:0] inv_cell;
  logic                         pivot_set;
  longint                       pivot_vox [3];
  bit                           occupied [Cells];
  verdict_t                     verdicts [$];
  int                           errors;
  int                           beats_seen;

  // sign-magnitude Q16.16 scale, truncated toward zero
  function automatic longint voxel_of(logic signed [fpv_pkg::CoordWidth-1:0] c);
    longint     cs;
    logic [63:0] mag;
    logic [63:0] prod;
    cs = c;
    mag = (cs < 0) ? -cs : cs;
    prod = (mag * {32'd0, inv_cell}) >> 16;
    return (cs < 0) ? -longint'(prod) : longint'(prod);
  endfunction

  function automatic verdict_t classify_point(logic signed [fpv_pkg::CoordWidth-1:0] x,
                                              logic signed [fpv_pkg::CoordWidth-1:0] y,
                                              logic signed [fpv_pkg::CoordWidth-1:0] z);
    longint   vox [3];
    longint   off [3];
    longint   idx;
    bit       in_win;
    int       a;
    verdict_t v;
    vox[0] = voxel_of(x);
    vox[1] = voxel_of(y);
    vox[2] = voxel_of(z);
    if (!pivot_set) begin
      pivot_vox = vox;
      pivot_set = 1'b1;
    end
    in_win = 1'b1;
    for (a = 0; a < 3; a++) begin
      off[a] = vox[a] - pivot_vox[a];
      if (off[a] < -Half || off[a] >= Half) in_win = 1'b0;
    end
    v.outside = !in_win;
    v.keep = 1'b0;
    // bitmap only touched for points inside the window
    if (in_win) begin
      idx = ((off[2] + Half) * Side + (off[1] + Half)) * Side + (off[0] + Half);
      if (!occupied[idx]) begin
        occupied[idx] = 1'b1;
        v.keep = 1'b1;
      end
    end
    return v;
  endfunction

  function automatic void report(string why, verdict_t want, verdict_t got);
    errors++;
    if (errors <= 10)
      $display({"mismatch at verdict beat %0d (%s): expected keep=%0b outside=%0b,",
                " got keep=%0b outside=%0b"},
               beats_seen, why, want.keep, want.outside, got.keep, got.outside);
  endfunction

  always @(posedge clk) begin : watch
    verdict_t got;
    verdict_t want;
    if (rst) begin
      inv_cell = fpv_pkg::InvCellReset;
      pivot_set = 1'b0;
      pivot_vox = '{0, 0, 0};
      occupied = '{default: 1'b0};
      verdicts.delete();
      errors = 0;
      beats_seen = 0;
    end else begin
      if (cfg_valid && cfg_ready) inv_cell = inv_cell_q16;
      if (in_valid && !in_stall) verdicts.push_back(classify_point(coord_x, coord_y, coord_z));
      if (out_valid && !out_stall) begin
        got.keep = keep_point;
        got.outside = outside_window;
        if (verdicts.size() == 0) begin
          report("no point in flight", '0, got);
        end else begin
          want = verdicts.pop_front();
          if (got.keep !== want.keep || got.outside !== want.outside)
            report("field differs", want, got);
        end
        beats_seen++;
      end
    end
    fail_count <= errors;
    pending <= verdicts.size();
  end

endmodule

### dv/tb_first_point_per_voxel_filter_core.sv
// testbench top for first_point_per_voxel_filter_core: clock, reset, point and
// config stimulus, random stalls on both sides; checking is done in fpv_checker
// depends on fpv_pkg, fpv_checker and the core
module tb_first_point_per_voxel_filter_core;
  import fpv_pkg::*;

  localparam int unsigned GridBits = 6;
  localparam int HalfWin = 1 << (GridBits - 1);
  localparam int CycleLimit = 400000;
  localparam int PhaseCount = 10;
  localparam int PointsPerPhase = 183;
  localparam int HoldCycles = 400;
  localparam logic signed [CoordWidth-1:0] CoordMax = 32'sh7FFF_FFFF;
  localparam logic signed [CoordWidth-1:0] CoordMin = 32'sh8000_0000;

  logic                         clk;
  logic                         rst;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [InvWidth-1:0]          inv_cell_q16;
  logic                         in_valid;
  logic                         in_stall;
  logic signed [CoordWidth-1:0] coord_x;
  logic signed [CoordWidth-1:0] coord_y;
  logic signed [CoordWidth-1:0] coord_z;
  logic                         out_valid;
  logic                         out_stall;
  logic                         keep_point;
  logic                         outside_window;

  logic rx_busy;
  logic long_hold;
  assign out_stall = rx_busy | long_hold;

  int                           fail_count;
  int                           pending;
  int                           cycles = 0;
  int                           tx_gap_max;
  int                           rx_stall_max;
  bit                           hold_req;
  logic [InvWidth-1:0]          cur_inv;
  longint                       pivot_vox [3];
  logic signed [CoordWidth-1:0] recent [16][3];
  int                           recent_n;

  first_point_per_voxel_filter_core #(.GRID_BITS(GridBits)) dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .inv_cell_q16   (inv_cell_q16),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .coord_x        (coord_x),
    .coord_y        (coord_y),
    .coord_z        (coord_z),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .keep_point     (keep_point),
    .outside_window (outside_window)
  );

  fpv_checker #(.GRID_BITS(GridBits)) u_verdict_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .inv_cell_q16   (inv_cell_q16),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .coord_x        (coord_x),
    .coord_y        (coord_y),
    .coord_z        (coord_z),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .keep_point     (keep_point),
    .outside_window (outside_window),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // verdict side: random stall before each beat
  initial begin : drain_verdicts
    int n;
    rx_busy <= 1'b0;
    forever begin
      n = $urandom_range(0, rx_stall_max);
      if (n > 0) begin
        rx_busy <= 1'b1;
        repeat (n) @(posedge clk);
      end
      rx_busy <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // one long hold-off so the core backs up and stalls its point input
  initial begin : hold_off
    long_hold <= 1'b0;
    wait (hold_req);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk);
    long_hold <= 1'b0;
  end

  task automatic send_point(input logic signed [CoordWidth-1:0] x,
                            input logic signed [CoordWidth-1:0] y,
                            input logic signed [CoordWidth-1:0] z);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    coord_x <= x;
    coord_y <= y;
    coord_z <= z;
    do @(posedge clk); while (in_stall);
    recent[recent_n % 16] = '{x, y, z};
    recent_n++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_inv(input logic [InvWidth-1:0] v);
    settle();
    cfg_valid <= 1'b1;
    inv_cell_q16 <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_inv = v;
  endtask

  // mostly points aimed at voxels near the pivot, some revisits, some noise
  task automatic pick_point(output logic signed [CoordWidth-1:0] x,
                            output logic signed [CoordWidth-1:0] y,
                            output logic signed [CoordWidth-1:0] z);
    logic signed [CoordWidth-1:0] c [3];
    longint step;
    longint off;
    longint target;
    int kind;
    int h;
    int a;
    kind = $urandom_range(0, 99);
    step = (cur_inv == 0) ? 0 : 65536 / longint'(cur_inv);
    if (kind < 30 && recent_n > 0) begin
      h = $urandom_range(0, ((recent_n < 16) ? recent_n : 16) - 1);
      c = recent[h];
    end else if (kind < 80 && cur_inv != 0) begin
      for (a = 0; a < 3; a++) begin
        if (kind < 60) off = int'($urandom_range(0, 7)) - 4;
        else off = int'($urandom_range(0, 2 * HalfWin + 3)) - HalfWin - 2;
        target = ((pivot_vox[a] + off) * 65536) / longint'(cur_inv);
        if (step > 0) target += longint'($urandom_range(0, 2 * step)) - step;
        if (target > longint'(CoordMax)) target = CoordMax;
        if (target < longint'(CoordMin)) target = CoordMin;
        c[a] = 32'(target);
      end
    end else if (kind < 90) begin
      for (a = 0; a < 3; a++) c[a] = $urandom;
    end else begin
      for (a = 0; a < 3; a++) c[a] = int'($urandom_range(0, 400)) - 200;
    end
    x = c[0];
    y = c[1];
    z = c[2];
  endtask

  initial begin : stimulus
    int p;
    int n;
    int a;
    int bx;
    int by;
    int bz;
    logic [InvWidth-1:0] nv;
    logic signed [CoordWidth-1:0] x;
    logic signed [CoordWidth-1:0] y;
    logic signed [CoordWidth-1:0] z;
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    inv_cell_q16 <= '0;
    in_valid <= 1'b0;
    coord_x <= '0;
    coord_y <= '0;
    coord_z <= '0;
    tx_gap_max = 2;
    rx_stall_max = 2;
    hold_req = 1'b0;
    recent_n = 0;
    cur_inv = InvCellReset;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // first point sets the pivot; at reset scale one raw unit is 1000 voxels
    for (a = 0; a < 3; a++) pivot_vox[a] = (int'($urandom_range(0, 4)) - 2) * 1000;
    bx = int'(pivot_vox[0]);
    by = int'(pivot_vox[1]);
    bz = int'(pivot_vox[2]);
    send_point(bx / 1000, by / 1000, bz / 1000);
    send_point(bx / 1000, by / 1000, bz / 1000);
    send_point(bx / 1000 + 1, by / 1000, bz / 1000);
    send_point(CoordMax, CoordMax, CoordMax);
    send_point(CoordMin, CoordMin, CoordMin);
    send_point(CoordMin, CoordMax, 0);

    // unit scale: walk the window edges on each axis
    write_inv(32'd65536);
    send_point(bx - HalfWin, by, bz);
    send_point(bx + HalfWin - 1, by, bz);
    send_point(bx - HalfWin - 1, by, bz);
    send_point(bx + HalfWin, by, bz);
    send_point(bx, by - HalfWin, bz);
    send_point(bx, by + HalfWin, bz);
    send_point(bx, by, bz + HalfWin - 1);
    send_point(bx, by, bz - HalfWin - 1);
    send_point(bx - HalfWin, by - HalfWin, bz - HalfWin);
    send_point(bx + HalfWin - 1, by + HalfWin - 1, bz + HalfWin - 1);
    send_point(bx + HalfWin - 1, by + HalfWin - 1, bz + HalfWin - 1);

    // half scale: odd coordinates land on truncation toward zero
    write_inv(32'd32768);
    send_point(2 * bx + 1, 2 * by, 2 * bz);
    send_point(2 * bx - 1, 2 * by - 1, 2 * bz - 1);

    // zero reciprocal folds every point onto voxel zero
    write_inv(32'd0);
    send_point(CoordMax, CoordMin, 12345);
    send_point(-1, 1, 0);

    for (p = 0; p < PhaseCount; p++) begin
      case (p)
        0: nv = 32'd65536;
        1: nv = 32'd1;
        2: nv = 32'hFFFF_FFFF;
        3: nv = 32'd4096;
        4: nv = 32'd98304;
        5: nv = InvCellReset;
        6: nv = $urandom_range(1, 32'h0004_0000);
        7: nv = 32'd0;
        8: nv = 32'd32768;
        default: nv = $urandom;
      endcase
      write_inv(nv);
      case (p % 3)
        0: tx_gap_max = 0;
        1: tx_gap_max = 14;
        default: tx_gap_max = 3;
      endcase
      case (p % 4)
        0: rx_stall_max = 0;
        1: rx_stall_max = 14;
        2: rx_stall_max = 5;
        default: rx_stall_max = 14;
      endcase
      if (p == 0) hold_req = 1'b1;
      for (n = 0; n < PointsPerPhase; n++) begin
        pick_point(x, y, z);
        send_point(x, y, z);
      end
    end

    settle();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
